[design/cpsc_pkg.sv]
`timescale 1ns / 1ps

package cpsc_pkg;

	// width of one item id on the ports
	localparam int ITEM_W = 10;

	// width of one saturating presence count
	localparam int PRES_W = 2;

	// saturation level of a presence count
	localparam logic [PRES_W-1:0] PRES_MAX = 2'd3;

	// one stored incompatible pair
	typedef struct packed {
		logic [ITEM_W-1:0] a;
		logic [ITEM_W-1:0] b;
	} pair_t;

endpackage

[design/cpsc_pair_mem.sv]
`timescale 1ns / 1ps

module cpsc_pair_mem
	import cpsc_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  pair_t         wdata,
	input  logic [AW-1:0] raddr,
	output pair_t         rdata
);

	pair_t mem [DEPTH];

	// single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[design/cpsc_pres_mem.sv]
`timescale 1ns / 1ps

module cpsc_pres_mem
	import cpsc_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [PRES_W-1:0] wdata,
	input  logic [AW-1:0]     raddr_a,
	input  logic [AW-1:0]     raddr_b,
	output logic [PRES_W-1:0] rdata_a,
	output logic [PRES_W-1:0] rdata_b
);

	logic [PRES_W-1:0] mem [DEPTH];

	// single write port, read before write on a collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// two registered read ports
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

[design/conflict_pair_set_checker.sv]
`timescale 1ns / 1ps

// Conflict pair set checker.
// Input channel (in_valid/in_stall): mode 0 beats store an incompatible pair
// (item_a, item_b) in the pair table; pairs past MAX_PAIRS are dropped and
// set the sticky pair_overflow flag. Mode 1 beats add item_a to the query set;
// the beat with last high ends the set.
// Output channel (out_valid/out_stall): one beat per finished set carrying
// safe, set_overflow and pair_overflow. No beat for any other input.
// Throughput: pair beats and non-final item beats are taken one per cycle.
// After the final item the pair table is scanned one pair per cycle through
// a read pipeline (table read, then presence read on two ports), then the
// presence memory is cleared one entry per cycle over min(ID_COUNT,1024)
// entries. in_stall is high during scan, result hand-off and clear. The
// result waits in the done state while an earlier result is stalled.
// Reset: the presence memory is swept to zero, min(ID_COUNT,1024) entries,
// with in_stall high. The pair table needs no clearing.
// A stalled result stays in the output register; new items are still taken,
// and a later scan holds its result until the register frees up.

module conflict_pair_set_checker
	import cpsc_pkg::*;
#(
	parameter int ID_COUNT  = 1024,
	parameter int MAX_PAIRS = 1024,
	parameter int MAX_SET   = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              mode,
	input  logic [ITEM_W-1:0] item_a,
	input  logic [ITEM_W-1:0] item_b,
	input  logic              last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              safe,
	output logic              set_overflow,
	output logic              pair_overflow
);

	localparam int PRES_DEPTH = (ID_COUNT < (1 << ITEM_W)) ? ID_COUNT : (1 << ITEM_W);
	localparam int PRES_AW    = (PRES_DEPTH > 1) ? $clog2(PRES_DEPTH) : 1;
	localparam int PT_AW      = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
	localparam int PC_W       = $clog2(MAX_PAIRS + 1);
	localparam int SC_W       = $clog2(MAX_SET + 1);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_RUN,
		S_SCAN,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [PC_W-1:0]     pair_count_q;
	logic                dropped_q;
	logic [SC_W-1:0]     set_cnt_q;
	logic                set_ovf_q;
	logic                res_ovf_q;
	logic [PRES_AW-1:0]  clr_idx_q;
	logic [PC_W-1:0]     scn_idx_q;
	logic                safe_q;
	logic                out_valid_q;
	logic                safe_out_q;
	logic                set_ovf_out_q;
	logic                pair_ovf_out_q;

	// item update pipeline and forwarding register
	logic                itm_v_s1;
	logic [PRES_AW-1:0]  itm_a_s1;
	logic                fwd_v_q;
	logic [PRES_AW-1:0]  fwd_a_q;
	logic [PRES_W-1:0]   fwd_d_q;

	// scan pipeline
	logic                scn_v_s1;
	logic                scn_v_s2;
	logic                scn_eq_s2;
	logic                scn_ina_s2;
	logic                scn_inb_s2;

	logic                in_fire;
	logic                pair_fire;
	logic                item_fire;
	logic                set_room;
	logic                item_inr;
	logic                pair_room;
	logic                scn_issue;
	logic                scn_end;
	logic                conflict;
	logic                ina;
	logic                inb;
	logic [PRES_W-1:0]   pres_old;
	logic [PRES_W-1:0]   pres_new;

	pair_t               pair_wdata;
	pair_t               pair_rdata;
	logic [PT_AW-1:0]    pair_raddr;

	logic                pres_we;
	logic [PRES_AW-1:0]  pres_waddr;
	logic [PRES_W-1:0]   pres_wdata;
	logic [PRES_AW-1:0]  pres_raddr_a;
	logic [PRES_AW-1:0]  pres_raddr_b;
	logic [PRES_W-1:0]   pres_rdata_a;
	logic [PRES_W-1:0]   pres_rdata_b;

	// input handshake and decode
	assign in_stall  = (state_q != S_RUN);
	assign in_fire   = in_valid && !in_stall;
	assign pair_fire = in_fire && !mode;
	assign item_fire = in_fire && mode;
	assign pair_room = (pair_count_q < PC_W'(MAX_PAIRS));
	assign set_room  = (set_cnt_q < SC_W'(MAX_SET));
	assign item_inr  = ({22'd0, item_a} < 32'(ID_COUNT));

	// pair table
	assign pair_wdata.a = item_a;
	assign pair_wdata.b = item_b;
	assign pair_raddr   = scn_idx_q[PT_AW-1:0];

	cpsc_pair_mem #(
		.DEPTH (MAX_PAIRS),
		.AW    (PT_AW)
	) u_pair_mem (
		.clk   (clk),
		.we    (pair_fire && pair_room),
		.waddr (pair_count_q[PT_AW-1:0]),
		.wdata (pair_wdata),
		.raddr (pair_raddr),
		.rdata (pair_rdata)
	);

	// presence read-modify-write with forwarding of the previous write
	assign pres_old = (fwd_v_q && (fwd_a_q == itm_a_s1)) ? fwd_d_q : pres_rdata_a;
	assign pres_new = (pres_old == PRES_MAX) ? PRES_MAX : pres_old + PRES_W'(1);

	assign pres_we      = itm_v_s1 || (state_q == S_CLEAR);
	assign pres_waddr   = itm_v_s1 ? itm_a_s1 : clr_idx_q;
	assign pres_wdata   = itm_v_s1 ? pres_new : '0;
	assign pres_raddr_a = (state_q == S_RUN) ? item_a[PRES_AW-1:0]
	                                         : pair_rdata.a[PRES_AW-1:0];
	assign pres_raddr_b = pair_rdata.b[PRES_AW-1:0];

	cpsc_pres_mem #(
		.DEPTH (PRES_DEPTH),
		.AW    (PRES_AW)
	) u_pres_mem (
		.clk     (clk),
		.we      (pres_we),
		.waddr   (pres_waddr),
		.wdata   (pres_wdata),
		.raddr_a (pres_raddr_a),
		.raddr_b (pres_raddr_b),
		.rdata_a (pres_rdata_a),
		.rdata_b (pres_rdata_b)
	);

	// scan control and per-pair conflict test
	assign scn_issue = (state_q == S_SCAN) && (scn_idx_q != pair_count_q);
	assign scn_end   = (state_q == S_SCAN) && (scn_idx_q == pair_count_q)
	                   && !scn_v_s1 && !scn_v_s2;
	assign ina       = ({22'd0, pair_rdata.a} < 32'(ID_COUNT));
	assign inb       = ({22'd0, pair_rdata.b} < 32'(ID_COUNT));
	assign conflict  = scn_v_s2 && scn_ina_s2 && (scn_eq_s2
	                   ? (pres_rdata_a >= PRES_W'(2))
	                   : (scn_inb_s2 && (pres_rdata_a != '0) && (pres_rdata_b != '0)));

	// item and scan pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			itm_v_s1 <= 1'b0;
			fwd_v_q  <= 1'b0;
			scn_v_s1 <= 1'b0;
			scn_v_s2 <= 1'b0;
		end else begin
			itm_v_s1 <= item_fire && set_room && item_inr;
			fwd_v_q  <= itm_v_s1;
			scn_v_s1 <= scn_issue;
			scn_v_s2 <= scn_v_s1;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		itm_a_s1   <= item_a[PRES_AW-1:0];
		fwd_a_q    <= itm_a_s1;
		fwd_d_q    <= pres_new;
		scn_eq_s2  <= (pair_rdata.a == pair_rdata.b);
		scn_ina_s2 <= ina;
		scn_inb_s2 <= inb;
	end

	// main state machine, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			pair_count_q   <= '0;
			dropped_q      <= 1'b0;
			set_cnt_q      <= '0;
			set_ovf_q      <= 1'b0;
			res_ovf_q      <= 1'b0;
			clr_idx_q      <= '0;
			scn_idx_q      <= '0;
			safe_q         <= 1'b1;
			out_valid_q    <= 1'b0;
			safe_out_q     <= 1'b0;
			set_ovf_out_q  <= 1'b0;
			pair_ovf_out_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + PRES_AW'(1);
					if (clr_idx_q == PRES_AW'(PRES_DEPTH - 1)) begin
						clr_idx_q <= '0;
						state_q   <= S_RUN;
					end
				end
				S_RUN: begin
					if (pair_fire) begin
						if (pair_room) begin
							pair_count_q <= pair_count_q + PC_W'(1);
						end else begin
							dropped_q <= 1'b1;
						end
					end
					if (item_fire) begin
						if (set_room) begin
							set_cnt_q <= set_cnt_q + SC_W'(1);
						end else begin
							set_ovf_q <= 1'b1;
						end
						if (last) begin
							res_ovf_q <= set_ovf_q || !set_room;
							set_cnt_q <= '0;
							set_ovf_q <= 1'b0;
							scn_idx_q <= '0;
							safe_q    <= 1'b1;
							state_q   <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scn_issue) begin
						scn_idx_q <= scn_idx_q + PC_W'(1);
					end
					if (conflict) begin
						safe_q <= 1'b0;
					end
					if (scn_end) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q    <= 1'b1;
						safe_out_q     <= safe_q;
						set_ovf_out_q  <= res_ovf_q;
						pair_ovf_out_q <= dropped_q;
						clr_idx_q      <= '0;
						state_q        <= S_CLEAR;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign safe          = safe_out_q;
	assign set_overflow  = set_ovf_out_q;
	assign pair_overflow = pair_ovf_out_q;

	// checks
	a_last_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && mode && last) |=> (state_q == S_SCAN))
		else $error("final item did not start the pair scan");

	a_item_write_not_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		itm_v_s1 |-> (state_q != S_CLEAR))
		else $error("presence update collides with clearing pass");

	a_pair_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pair_count_q <= PC_W'(MAX_PAIRS))
		else $error("pair count beyond capacity");

	a_scan_pipe_order: assert property (@(posedge clk) disable iff (!arst_n)
		scn_v_s1 |-> $past(scn_issue))
		else $error("scan pipeline beat without table read");

	a_set_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		set_cnt_q <= SC_W'(MAX_SET))
		else $error("set count beyond capacity");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import cpsc_pkg::*;

	localparam int ID_COUNT     = 1024;
	localparam int MAX_PAIRS    = 1024;
	localparam int MAX_SET      = 256;
	localparam int HOT_IDS      = 48;
	localparam int ITEM_BUDGET  = 1900;
	localparam int DRAIN_CYCLES = MAX_PAIRS + ID_COUNT + 200;
	localparam int unsigned CYCLE_LIMIT = 40_000_000;

	typedef enum logic {
		MODE_PAIR  = 1'b0,
		MODE_QUERY = 1'b1
	} beat_mode_e;

	typedef struct packed {
		logic safe;
		logic set_ovf;
		logic pair_ovf;
	} verdict_t;

	// mirror of the pair table and query set, queue of verdicts owed
	class conflict_scoreboard;
		pair_t             pair_table[MAX_PAIRS];
		int                pair_total;
		bit                pairs_lost;
		logic [ITEM_W-1:0] members[$];
		int                member_total;
		bit [PRES_W-1:0]   presence[ID_COUNT];
		verdict_t          verdicts_due[$];
		int                errors;

		function int pending();
			return verdicts_due.size();
		endfunction

		function void note_beat(logic m, logic [ITEM_W-1:0] a, logic [ITEM_W-1:0] b,
				logic l);
			verdict_t v;
			logic [ITEM_W-1:0] pa;
			logic [ITEM_W-1:0] pb;
			// pair beats only grow the table, or raise the sticky drop flag
			if (m == MODE_PAIR) begin
				if (pair_total < MAX_PAIRS) begin
					pair_table[pair_total] = {a, b};
					pair_total++;
				end else begin
					pairs_lost = 1'b1;
				end
				return;
			end
			// query item takes a slot while the set has room
			if (member_total < MAX_SET) begin
				members = {members, a};
				member_total++;
				if (presence[a] != PRES_MAX)
					presence[a]++;
			end else begin
				member_total = MAX_SET + 1;
			end
			if (!l)
				return;
			// scan every stored pair against the membership counts
			v.safe = 1'b1;
			for (int i = 0; i < pair_total; i++) begin
				pa = pair_table[i].a;
				pb = pair_table[i].b;
				if (pa == pb) begin
					if (presence[pa] >= 2)
						v.safe = 1'b0;
				end else if (presence[pa] != 0 && presence[pb] != 0) begin
					v.safe = 1'b0;
				end
			end
			v.set_ovf  = (member_total > MAX_SET);
			v.pair_ovf = pairs_lost;
			verdicts_due = {verdicts_due, v};
			// forget the finished set
			foreach (members[k])
				presence[members[k]] = '0;
			members.delete();
			member_total = 0;
		endfunction

		function void check_verdict(logic s, logic so, logic po);
			verdict_t want;
			if (verdicts_due.size() == 0) begin
				$error("result beat with no finished set pending");
				errors++;
				return;
			end
			want = verdicts_due.pop_front();
			if (s !== want.safe) begin
				$error("safe: expected %0b, actual %0b", want.safe, s);
				errors++;
			end
			if (so !== want.set_ovf) begin
				$error("set_overflow: expected %0b, actual %0b", want.set_ovf, so);
				errors++;
			end
			if (po !== want.pair_ovf) begin
				$error("pair_overflow: expected %0b, actual %0b", want.pair_ovf, po);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              mode = 1'b0;
	logic [ITEM_W-1:0] item_a = '0;
	logic [ITEM_W-1:0] item_b = '0;
	logic              last = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              safe;
	logic              set_overflow;
	logic              pair_overflow;

	conflict_scoreboard sb = new;

	bit          valid_up;
	int          items_sent;
	int          pairs_sent;
	int          burst_left;
	int unsigned cycle_count;
	int unsigned open_left;
	int unsigned shut_left;

	conflict_pair_set_checker #(
		.ID_COUNT (ID_COUNT),
		.MAX_PAIRS(MAX_PAIRS),
		.MAX_SET  (MAX_SET)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.item_a       (item_a),
		.item_b       (item_b),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.safe         (safe),
		.set_overflow (set_overflow),
		.pair_overflow(pair_overflow)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver: open stretches, short stalls, rare very long stalls
	always @(posedge clk) begin
		if (shut_left != 0) begin
			out_stall <= 1'b1;
			shut_left <= shut_left - 1;
		end else if (open_left != 0) begin
			out_stall <= 1'b0;
			open_left <= open_left - 1;
		end else begin
			out_stall <= 1'b0;
			open_left <= $urandom_range(1, 48);
			if ($urandom_range(0, 199) == 0)
				shut_left <= $urandom_range(500, 2500);
			else if ($urandom_range(0, 2) == 0)
				shut_left <= 0;
			else
				shut_left <= $urandom_range(1, 24);
		end
	end

	// beat monitors on both channels
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_beat(mode, item_a, item_b, last);
		if (arst_n && out_valid && !out_stall)
			sb.check_verdict(safe, set_overflow, pair_overflow);
	end

	// drop valid if it is up, then idle for the given number of cycles
	task automatic rest_sender(int cycles);
		if (valid_up) begin
			in_valid <= 1'b0;
			valid_up = 1'b0;
		end
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_drained();
		rest_sender(1);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// one input beat, held until taken, then the burst pacing
	task automatic send_beat(beat_mode_e m, logic [ITEM_W-1:0] a, logic [ITEM_W-1:0] b,
			logic l);
		in_valid <= 1'b1;
		mode     <= m;
		item_a   <= a;
		item_b   <= b;
		last     <= l;
		valid_up = 1'b1;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		items_sent++;
		if (m == MODE_PAIR)
			pairs_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			if ($urandom_range(0, 3) == 0)
				burst_left = $urandom_range(40, 120);
			else
				burst_left = $urandom_range(1, 16);
			rest_sender($urandom_range(1, 6));
		end
	endtask

	// ids come mostly from a small hot pool so that sets hit stored pairs
	function automatic logic [ITEM_W-1:0] pick_id(int hot_pct);
		if ($urandom_range(0, 99) < hot_pct)
			return ITEM_W'($urandom_range(0, HOT_IDS - 1));
		return ITEM_W'($urandom_range(0, ID_COUNT - 1));
	endfunction

	task automatic send_pairs(int count);
		logic [ITEM_W-1:0] a;
		logic [ITEM_W-1:0] b;
		repeat (count) begin
			a = pick_id(40);
			b = ($urandom_range(0, 9) == 0) ? a : pick_id(40);
			send_beat(MODE_PAIR, a, b, 1'($urandom_range(0, 1)));
		end
	endtask

	// query set with some repeated ids, last marker on the final beat
	task automatic send_set(int len, int hot_pct);
		logic [ITEM_W-1:0] id;
		logic [ITEM_W-1:0] prev;
		prev = pick_id(hot_pct);
		for (int k = 0; k < len; k++) begin
			id = ($urandom_range(0, 5) == 0) ? prev : pick_id(hot_pct);
			send_beat(MODE_QUERY, id, ITEM_W'($urandom_range(0, ID_COUNT - 1)),
				k == len - 1);
			prev = id;
		end
	endtask

	initial begin
		int round;
		int len;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// lone item against an empty table
		send_beat(MODE_QUERY, 10'd5, 10'd0, 1'b1);
		// self pair, extreme ids, alternating bit patterns, last on a pair beat
		send_beat(MODE_PAIR, 10'd5, 10'd5, 1'b0);
		send_beat(MODE_PAIR, 10'd0, 10'd1023, 1'b0);
		send_beat(MODE_PAIR, 10'd682, 10'd341, 1'b0);
		send_beat(MODE_PAIR, 10'd7, 10'd9, 1'b0);
		send_beat(MODE_PAIR, 10'd100, 10'd200, 1'b1);
		// self pair item once, then twice
		send_beat(MODE_QUERY, 10'd5, 10'd1023, 1'b1);
		send_beat(MODE_QUERY, 10'd5, 10'd0, 1'b0);
		send_beat(MODE_QUERY, 10'd5, 10'd0, 1'b1);
		// pair ends in swapped order
		send_beat(MODE_QUERY, 10'd1023, 10'd0, 1'b0);
		send_beat(MODE_QUERY, 10'd0, 10'd0, 1'b1);
		send_beat(MODE_QUERY, 10'd341, 10'd1023, 1'b0);
		send_beat(MODE_QUERY, 10'd682, 10'd0, 1'b1);
		// near miss, then one end twice
		send_beat(MODE_QUERY, 10'd7, 10'd1023, 1'b0);
		send_beat(MODE_QUERY, 10'd8, 10'd0, 1'b1);
		send_beat(MODE_QUERY, 10'd1023, 10'd0, 1'b0);
		send_beat(MODE_QUERY, 10'd1023, 10'd0, 1'b1);
		send_beat(MODE_QUERY, 10'd200, 10'd0, 1'b0);
		send_beat(MODE_QUERY, 10'd100, 10'd0, 1'b1);
		// presence count saturates
		send_beat(MODE_QUERY, 10'd9, 10'd0, 1'b0);
		send_beat(MODE_QUERY, 10'd9, 10'd0, 1'b0);
		send_beat(MODE_QUERY, 10'd9, 10'd0, 1'b0);
		send_beat(MODE_QUERY, 10'd9, 10'd0, 1'b0);
		send_beat(MODE_QUERY, 10'd7, 10'd0, 1'b1);
		wait_drained();

		// random rounds: a few pairs, then one set; one full set, one overfull set
		// the pairs still owed to fill the table count toward the budget
		round = 0;
		while (items_sent + (MAX_PAIRS + 4 - pairs_sent) < ITEM_BUDGET) begin
			send_pairs($urandom_range(0, 14));
			if (round == 20)
				len = MAX_SET;
			else if (round == 50)
				len = $urandom_range(MAX_SET + 1, MAX_SET + 4);
			else
				len = $urandom_range(1, 8);
			send_set(len, (len > 8) ? 10 : 60);
			if ($urandom_range(0, 24) == 0)
				wait_drained();
			round++;
		end

		// push the table past capacity, then sets that carry the sticky flag
		while (pairs_sent <= MAX_PAIRS + 3)
			send_pairs(1);
		repeat (4)
			send_set($urandom_range(1, 8), 60);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
